[hw/rtl/mvn_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvn_pkg
// Shared types, codes and helpers for the mesh vertex normal engine.
// ----------------------------------------------------------------------------
package mvn_pkg;

    // default sizes
    localparam int MAX_VERTICES_DEF  = 1024;
    localparam int MAX_TRIANGLES_DEF = 2048;
    localparam int COORD_WIDTH_DEF   = 16;

    // fixed field widths
    localparam int CORNER_W = 10;
    localparam int POS_W    = 16;
    localparam int NORM_W   = 16;
    localparam int ACC_W    = 24;
    localparam int NIN_W    = 36;

    typedef enum logic [1:0] {
        MODE_VERTEX   = 2'd0,
        MODE_TRIANGLE = 2'd1,
        MODE_COMPUTE  = 2'd2,
        MODE_QUERY    = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2,
        ST_ZERO  = 2'd3
    } status_t;

    // result of the normalize unit
    typedef struct packed {
        logic                     zero;
        logic signed [NORM_W-1:0] x;
        logic signed [NORM_W-1:0] y;
        logic signed [NORM_W-1:0] z;
    } norm_res_t;

    // normalize unit sequencer
    typedef enum logic [2:0] {
        N_IDLE,
        N_SHIFT,
        N_SQ,
        N_SQRT,
        N_DIVLD,
        N_DIV,
        N_DSTORE,
        N_DONE
    } norm_state_t;

    // top level sequencer
    typedef enum logic [4:0] {
        S_IDLE,
        S_DISP,
        S_QWAIT,
        S_CLR,
        S_TCHK,
        S_TA,
        S_TB,
        S_TC,
        S_TD,
        S_XMUL,
        S_FSTART,
        S_FWAIT,
        S_ARD,
        S_AWR,
        S_VCHK,
        S_VSTART,
        S_VWAIT,
        S_RESP
    } top_state_t;

    // saturating accumulate of a unit component
    function automatic logic signed [ACC_W-1:0] sat_add(
        input logic signed [ACC_W-1:0]  acc,
        input logic signed [NORM_W-1:0] f
    );
        logic signed [ACC_W:0] s;
        s = (ACC_W + 1)'(acc) + (ACC_W + 1)'(f);
        if (s[ACC_W] != s[ACC_W-1]) begin
            return s[ACC_W] ? {1'b1, {(ACC_W - 1){1'b0}}} : {1'b0, {(ACC_W - 1){1'b1}}};
        end
        return s[ACC_W-1:0];
    endfunction

endpackage

[hw/rtl/mvn_norm.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvn_norm
// Iterative Q1.14 vector normalizer: align shift, sum of squares on one
// multiplier, bit-serial square root and three restoring divisions.
// ----------------------------------------------------------------------------
module mvn_norm
    import mvn_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic signed [NIN_W-1:0] in_x,
    input  logic signed [NIN_W-1:0] in_y,
    input  logic signed [NIN_W-1:0] in_z,
    output logic                    done,
    output norm_res_t               res
);

    norm_state_t state_reg, state_next;

    logic [NIN_W-1:0]  u_reg [3];
    logic              sgn_reg [3];
    logic [59:0]       prod_reg;
    logic [61:0]       sum_reg;
    logic [61:0]       v_reg;
    logic [33:0]       rem_reg;
    logic [30:0]       root_reg;
    logic [30:0]       len_reg;
    logic [31:0]       drem_reg;
    logic [14:0]       numlo_reg;
    logic [14:0]       q_reg;
    logic [4:0]        cnt_reg;
    logic [1:0]        k_reg;
    norm_res_t         res_reg;

    logic              any_high, all_low, all_zero;
    logic [29:0]       sq_op;
    logic [61:0]       sum_fin;
    logic [33:0]       rem_n, trial;
    logic [30:0]       root_n;
    logic [33:0]       rem_upd;
    logic [NIN_W-1:0]  div_u;
    logic [44:0]       num;
    logic [31:0]       drem_n, drem_upd;
    logic [14:0]       q_n;
    logic signed [NORM_W-1:0] q_signed;

    function automatic logic [NIN_W-1:0] mag(input logic signed [NIN_W-1:0] v);
        return v[NIN_W-1] ? NIN_W'(-v) : NIN_W'(v);
    endfunction

    // alignment tests
    assign any_high = (|u_reg[0][NIN_W-1:30]) | (|u_reg[1][NIN_W-1:30])
                    | (|u_reg[2][NIN_W-1:30]);
    assign all_low  = ~((|u_reg[0][NIN_W-1:29]) | (|u_reg[1][NIN_W-1:29])
                    | (|u_reg[2][NIN_W-1:29]));
    assign all_zero = (u_reg[0] == '0) && (u_reg[1] == '0) && (u_reg[2] == '0);

    // square operand select
    always_comb begin
        case (cnt_reg[1:0])
            2'd0:    sq_op = u_reg[0][29:0];
            2'd1:    sq_op = u_reg[1][29:0];
            default: sq_op = u_reg[2][29:0];
        endcase
    end
    assign sum_fin = sum_reg + 62'(prod_reg);

    // one square root digit
    always_comb begin
        rem_n = {rem_reg[31:0], v_reg[61:60]};
        trial = {1'b0, root_reg, 2'b01};
        if (rem_n >= trial) begin
            rem_upd = rem_n - trial;
            root_n  = {root_reg[29:0], 1'b1};
        end else begin
            rem_upd = rem_n;
            root_n  = {root_reg[29:0], 1'b0};
        end
    end

    // division setup and one quotient bit
    always_comb begin
        case (k_reg)
            2'd0:    div_u = u_reg[0];
            2'd1:    div_u = u_reg[1];
            default: div_u = u_reg[2];
        endcase
        num    = {1'b0, div_u[29:0], 14'd0} + 45'(len_reg[30:1]);
        drem_n = {drem_reg[30:0], numlo_reg[14]};
        if (drem_n >= {1'b0, len_reg}) begin
            drem_upd = drem_n - {1'b0, len_reg};
            q_n      = {q_reg[13:0], 1'b1};
        end else begin
            drem_upd = drem_n;
            q_n      = {q_reg[13:0], 1'b0};
        end
    end

    always_comb begin
        logic sg;
        case (k_reg)
            2'd0:    sg = sgn_reg[0];
            2'd1:    sg = sgn_reg[1];
            default: sg = sgn_reg[2];
        endcase
        q_signed = sg ? -NORM_W'(q_reg) : NORM_W'(q_reg);
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= N_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            N_IDLE: begin
                if (start) state_next = N_SHIFT;
            end
            N_SHIFT: begin
                if (all_zero) state_next = N_DONE;
                else if (!any_high && !all_low) state_next = N_SQ;
            end
            N_SQ: begin
                if (cnt_reg == 5'd3) state_next = N_SQRT;
            end
            N_SQRT: begin
                if (cnt_reg == 5'd30) state_next = N_DIVLD;
            end
            N_DIVLD: state_next = N_DIV;
            N_DIV: begin
                if (cnt_reg == 5'd14) state_next = N_DSTORE;
            end
            N_DSTORE: begin
                state_next = (k_reg == 2'd2) ? N_DONE : N_DIVLD;
            end
            N_DONE:  state_next = N_IDLE;
            default: state_next = N_IDLE;
        endcase
    end

    // datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            N_IDLE: begin
                u_reg[0]   <= mag(in_x);
                u_reg[1]   <= mag(in_y);
                u_reg[2]   <= mag(in_z);
                sgn_reg[0] <= in_x[NIN_W-1];
                sgn_reg[1] <= in_y[NIN_W-1];
                sgn_reg[2] <= in_z[NIN_W-1];
                cnt_reg    <= '0;
                sum_reg    <= '0;
                k_reg      <= '0;
            end
            N_SHIFT: begin
                if (all_zero) begin
                    res_reg <= '{zero: 1'b1, x: '0, y: '0, z: '0};
                end else begin
                    res_reg.zero <= 1'b0;
                    if (any_high) begin
                        for (int i = 0; i < 3; i++) u_reg[i] <= u_reg[i] >> 1;
                    end else if (all_low) begin
                        for (int i = 0; i < 3; i++) u_reg[i] <= u_reg[i] << 1;
                    end
                end
            end
            N_SQ: begin
                prod_reg <= sq_op * sq_op;
                if (cnt_reg != 5'd0) sum_reg <= sum_fin;
                if (cnt_reg == 5'd3) begin
                    v_reg    <= sum_fin;
                    rem_reg  <= '0;
                    root_reg <= '0;
                    cnt_reg  <= '0;
                end else begin
                    cnt_reg <= cnt_reg + 5'd1;
                end
            end
            N_SQRT: begin
                rem_reg  <= rem_upd;
                root_reg <= root_n;
                v_reg    <= {v_reg[59:0], 2'b00};
                if (cnt_reg == 5'd30) begin
                    len_reg <= root_n;
                end
                cnt_reg <= (cnt_reg == 5'd30) ? 5'd0 : cnt_reg + 5'd1;
            end
            N_DIVLD: begin
                drem_reg  <= {2'b00, num[44:15]};
                numlo_reg <= num[14:0];
                q_reg     <= '0;
                cnt_reg   <= '0;
            end
            N_DIV: begin
                drem_reg  <= drem_upd;
                numlo_reg <= {numlo_reg[13:0], 1'b0};
                q_reg     <= q_n;
                cnt_reg   <= (cnt_reg == 5'd14) ? 5'd0 : cnt_reg + 5'd1;
            end
            N_DSTORE: begin
                case (k_reg)
                    2'd0:    res_reg.x <= q_signed;
                    2'd1:    res_reg.y <= q_signed;
                    default: res_reg.z <= q_signed;
                endcase
                k_reg <= k_reg + 2'd1;
            end
            default: begin
            end
        endcase
    end

    assign done = (state_reg == N_DONE);
    assign res  = res_reg;

endmodule

[hw/rtl/mesh_vertex_normal_engine_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mesh_vertex_normal_engine_unit
// Vertex and triangle stores with smooth vertex normal computation and query.
// ----------------------------------------------------------------------------
// Compute runs every triangle and then every vertex through the shared
// normalize unit. One word is handled at a time; the normalize unit and the
// stores, each with one read and one write port, set the compute time.
// Synchronous active-low reset clears counts and flags; stores are not
// cleared, accumulators are cleared by each compute.
module mesh_vertex_normal_engine_unit
    import mvn_pkg::*;
#(
    parameter int MAX_VERTICES  = MAX_VERTICES_DEF,
    parameter int MAX_TRIANGLES = MAX_TRIANGLES_DEF,
    parameter int COORD_WIDTH   = COORD_WIDTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // pos_x, pos_y, pos_z, corner_a, corner_b, corner_c, pad
    input  logic [1:0]  s_tuser,   // mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // normal_x, normal_y, normal_z
    output logic [1:0]  m_tuser    // status
);

    localparam int VW  = $clog2(MAX_VERTICES);
    localparam int TW  = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
    localparam int VCW = $clog2(MAX_VERTICES + 1);
    localparam int TCW = $clog2(MAX_TRIANGLES + 1);
    localparam int CWE = (COORD_WIDTH < POS_W) ? COORD_WIDTH : POS_W;

    top_state_t state_reg, state_next;

    // stores
    logic [3*POS_W-1:0] vmem [MAX_VERTICES];
    logic [3*VW-1:0]    tmem [MAX_TRIANGLES];
    logic [3*ACC_W-1:0] amem [MAX_VERTICES];
    logic [3*POS_W-1:0] vm_rdata_reg;
    logic [3*VW-1:0]    tm_rdata_reg;
    logic [3*ACC_W-1:0] am_rdata_reg;

    logic               vm_we, tm_we, am_we;
    logic [VW-1:0]      vm_raddr, am_raddr, am_waddr;
    logic [TW-1:0]      tm_raddr;
    logic [3*ACC_W-1:0] am_wdata;

    // item and control registers
    mode_t              mode_reg;
    logic [POS_W-1:0]   px_reg, py_reg, pz_reg;
    logic [CORNER_W-1:0] ca_reg, cb_reg, cc_reg;
    logic [VCW-1:0]     vcount_reg;
    logic [TCW-1:0]     tcount_reg;
    logic               valid_reg;
    logic               zero_met_reg;
    logic [VCW-1:0]     idx_reg;
    logic [TCW-1:0]     tidx_reg;
    logic [2:0]         cnt_reg;
    logic [1:0]         sel_reg;
    logic [VW-1:0]      corner_reg [3];
    logic signed [POS_W-1:0] pa_reg [3];
    logic signed [POS_W-1:0] pb_reg [3];
    logic signed [POS_W:0]   uu_reg [3];
    logic signed [POS_W:0]   vv_reg [3];
    logic signed [2*POS_W+1:0] prod_reg;
    logic signed [NIN_W-1:0] n_reg [3];
    logic signed [NORM_W-1:0] f_reg [3];

    // result and output registers
    logic signed [NORM_W-1:0] res_x_reg, res_y_reg, res_z_reg;
    status_t            res_st_reg;
    logic               m_tvalid_reg;
    logic [47:0]        m_tdata_reg;
    logic [1:0]         m_tuser_reg;

    // decode of the held item
    logic               vfull, tfull, tri_bad, q_bad;
    logic signed [CWE-1:0] cx, cy, cz;
    logic signed [POS_W-1:0] coord_x, coord_y, coord_z;
    logic [VW-1:0]      ia, ib, ic;
    logic [VW-1:0]      cur_corner;
    logic               out_free;

    // normalize unit
    logic               norm_start, norm_done;
    logic signed [NIN_W-1:0] norm_x, norm_y, norm_z;
    norm_res_t          norm_res;

    // multiplier operands
    logic signed [POS_W:0] mul_a, mul_b;
    logic [2:0]         pcnt;

    function automatic logic [VW-1:0] to_idx(input logic [CORNER_W-1:0] c);
        logic [CORNER_W+VW-1:0] e;
        e = {{VW{1'b0}}, c};
        return e[VW-1:0];
    endfunction

    function automatic logic out_of_range(input logic [CORNER_W-1:0] c,
                                          input logic [VCW-1:0] n);
        return {{VCW{1'b0}}, c} >= {{CORNER_W{1'b0}}, n};
    endfunction

    assign vfull   = (vcount_reg == VCW'(MAX_VERTICES));
    assign tfull   = (tcount_reg == TCW'(MAX_TRIANGLES));
    assign tri_bad = out_of_range(ca_reg, vcount_reg) || out_of_range(cb_reg, vcount_reg)
                  || out_of_range(cc_reg, vcount_reg);
    assign q_bad   = out_of_range(ca_reg, vcount_reg);
    assign ia      = to_idx(ca_reg);
    assign ib      = to_idx(cb_reg);
    assign ic      = to_idx(cc_reg);
    assign out_free = !m_tvalid_reg || m_tready;

    // coordinate sign extension from the active width
    always_comb begin
        cx = px_reg[CWE-1:0];
        cy = py_reg[CWE-1:0];
        cz = pz_reg[CWE-1:0];
        coord_x = POS_W'(cx);
        coord_y = POS_W'(cy);
        coord_z = POS_W'(cz);
    end

    always_comb begin
        case (sel_reg)
            2'd0:    cur_corner = corner_reg[0];
            2'd1:    cur_corner = corner_reg[1];
            default: cur_corner = corner_reg[2];
        endcase
    end

    // cross product operand schedule
    always_comb begin
        case (cnt_reg)
            3'd0:    begin mul_a = uu_reg[1]; mul_b = vv_reg[2]; end
            3'd1:    begin mul_a = uu_reg[2]; mul_b = vv_reg[1]; end
            3'd2:    begin mul_a = uu_reg[2]; mul_b = vv_reg[0]; end
            3'd3:    begin mul_a = uu_reg[0]; mul_b = vv_reg[2]; end
            3'd4:    begin mul_a = uu_reg[0]; mul_b = vv_reg[1]; end
            default: begin mul_a = uu_reg[1]; mul_b = vv_reg[0]; end
        endcase
    end
    assign pcnt = cnt_reg - 3'd1;

    // normalize input select
    always_comb begin
        if (state_reg == S_VSTART) begin
            norm_x = NIN_W'($signed(am_rdata_reg[ACC_W-1:0]));
            norm_y = NIN_W'($signed(am_rdata_reg[2*ACC_W-1:ACC_W]));
            norm_z = NIN_W'($signed(am_rdata_reg[3*ACC_W-1:2*ACC_W]));
        end else begin
            norm_x = n_reg[0];
            norm_y = n_reg[1];
            norm_z = n_reg[2];
        end
    end
    assign norm_start = (state_reg == S_FSTART) || (state_reg == S_VSTART);

    mvn_norm u_norm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (norm_start),
        .in_x    (norm_x),
        .in_y    (norm_y),
        .in_z    (norm_z),
        .done    (norm_done),
        .res     (norm_res)
    );

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and store controls
    always_comb begin
        state_next = state_reg;
        vm_we      = 1'b0;
        tm_we      = 1'b0;
        am_we      = 1'b0;
        vm_raddr   = ia;
        tm_raddr   = tidx_reg[TW-1:0];
        am_raddr   = ia;
        am_waddr   = idx_reg[VW-1:0];
        am_wdata   = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) state_next = S_DISP;
            end
            S_DISP: begin
                unique case (mode_reg)
                    MODE_VERTEX: begin
                        vm_we      = !vfull;
                        state_next = S_RESP;
                    end
                    MODE_TRIANGLE: begin
                        tm_we      = !tfull && !tri_bad;
                        state_next = S_RESP;
                    end
                    MODE_COMPUTE: state_next = S_CLR;
                    MODE_QUERY: begin
                        state_next = (q_bad || !valid_reg) ? S_RESP : S_QWAIT;
                    end
                    default: state_next = S_RESP;
                endcase
            end
            S_QWAIT: state_next = S_RESP;
            S_CLR: begin
                if (idx_reg == vcount_reg) begin
                    state_next = S_TCHK;
                end else begin
                    am_we = 1'b1;
                end
            end
            S_TCHK: begin
                state_next = (tidx_reg == tcount_reg) ? S_VCHK : S_TA;
            end
            S_TA: begin
                vm_raddr   = tm_rdata_reg[VW-1:0];
                state_next = S_TB;
            end
            S_TB: begin
                vm_raddr   = corner_reg[1];
                state_next = S_TC;
            end
            S_TC: begin
                vm_raddr   = corner_reg[2];
                state_next = S_TD;
            end
            S_TD: state_next = S_XMUL;
            S_XMUL: begin
                if (cnt_reg == 3'd6) state_next = S_FSTART;
            end
            S_FSTART: state_next = S_FWAIT;
            S_FWAIT: begin
                if (norm_done) state_next = S_ARD;
            end
            S_ARD: begin
                am_raddr   = cur_corner;
                state_next = S_AWR;
            end
            S_AWR: begin
                am_we    = 1'b1;
                am_waddr = cur_corner;
                am_wdata = {sat_add(am_rdata_reg[3*ACC_W-1:2*ACC_W], f_reg[2]),
                            sat_add(am_rdata_reg[2*ACC_W-1:ACC_W], f_reg[1]),
                            sat_add(am_rdata_reg[ACC_W-1:0], f_reg[0])};
                state_next = (sel_reg == 2'd2) ? S_TCHK : S_ARD;
            end
            S_VCHK: begin
                am_raddr   = idx_reg[VW-1:0];
                state_next = (idx_reg == vcount_reg) ? S_RESP : S_VSTART;
            end
            S_VSTART: state_next = S_VWAIT;
            S_VWAIT: begin
                if (norm_done) begin
                    am_we      = 1'b1;
                    am_wdata   = {ACC_W'(norm_res.z), ACC_W'(norm_res.y), ACC_W'(norm_res.x)};
                    state_next = S_VCHK;
                end
            end
            S_RESP: begin
                if (out_free) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // vertex store
    always_ff @(posedge aclk) begin
        if (vm_we) begin
            vmem[vcount_reg[VW-1:0]] <= {coord_z, coord_y, coord_x};
        end
        vm_rdata_reg <= vmem[vm_raddr];
    end

    // triangle store
    always_ff @(posedge aclk) begin
        if (tm_we) begin
            tmem[tcount_reg[TW-1:0]] <= {ic, ib, ia};
        end
        tm_rdata_reg <= tmem[tm_raddr];
    end

    // accumulator store
    always_ff @(posedge aclk) begin
        if (am_we) begin
            amem[am_waddr] <= am_wdata;
        end
        am_rdata_reg <= amem[am_raddr];
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vcount_reg   <= '0;
            tcount_reg   <= '0;
            valid_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (vm_we) begin
                vcount_reg <= vcount_reg + VCW'(1);
                valid_reg  <= 1'b0;
            end
            if (tm_we) begin
                tcount_reg <= tcount_reg + TCW'(1);
                valid_reg  <= 1'b0;
            end
            if (state_reg == S_VCHK && idx_reg == vcount_reg) begin
                valid_reg <= 1'b1;
            end
            if (state_reg == S_RESP && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                mode_reg <= mode_t'(s_tuser);
                px_reg   <= s_tdata[15:0];
                py_reg   <= s_tdata[31:16];
                pz_reg   <= s_tdata[47:32];
                ca_reg   <= s_tdata[57:48];
                cb_reg   <= s_tdata[67:58];
                cc_reg   <= s_tdata[77:68];
            end
            S_DISP: begin
                res_x_reg    <= '0;
                res_y_reg    <= '0;
                res_z_reg    <= '0;
                idx_reg      <= '0;
                tidx_reg     <= '0;
                zero_met_reg <= 1'b0;
                unique case (mode_reg)
                    MODE_VERTEX:   res_st_reg <= vfull ? ST_FULL : ST_OK;
                    MODE_TRIANGLE: res_st_reg <= tfull ? ST_FULL : (tri_bad ? ST_RANGE : ST_OK);
                    MODE_QUERY:    res_st_reg <= q_bad ? ST_RANGE : (!valid_reg ? ST_ZERO : ST_OK);
                    default:       res_st_reg <= ST_OK;
                endcase
            end
            S_QWAIT: begin
                res_x_reg <= am_rdata_reg[NORM_W-1:0];
                res_y_reg <= am_rdata_reg[ACC_W+NORM_W-1:ACC_W];
                res_z_reg <= am_rdata_reg[2*ACC_W+NORM_W-1:2*ACC_W];
                if (am_rdata_reg[NORM_W-1:0] == '0
                        && am_rdata_reg[ACC_W+NORM_W-1:ACC_W] == '0
                        && am_rdata_reg[2*ACC_W+NORM_W-1:2*ACC_W] == '0) begin
                    res_st_reg <= ST_ZERO;
                end
            end
            S_CLR: begin
                idx_reg <= (idx_reg == vcount_reg) ? '0 : idx_reg + VCW'(1);
            end
            S_TA: begin
                corner_reg[0] <= tm_rdata_reg[VW-1:0];
                corner_reg[1] <= tm_rdata_reg[2*VW-1:VW];
                corner_reg[2] <= tm_rdata_reg[3*VW-1:2*VW];
            end
            S_TB: begin
                pa_reg[0] <= vm_rdata_reg[POS_W-1:0];
                pa_reg[1] <= vm_rdata_reg[2*POS_W-1:POS_W];
                pa_reg[2] <= vm_rdata_reg[3*POS_W-1:2*POS_W];
            end
            S_TC: begin
                pb_reg[0] <= vm_rdata_reg[POS_W-1:0];
                pb_reg[1] <= vm_rdata_reg[2*POS_W-1:POS_W];
                pb_reg[2] <= vm_rdata_reg[3*POS_W-1:2*POS_W];
            end
            S_TD: begin
                // edge vectors c - a and b - a
                uu_reg[0] <= (POS_W + 1)'($signed(vm_rdata_reg[POS_W-1:0]))
                           - (POS_W + 1)'(pa_reg[0]);
                uu_reg[1] <= (POS_W + 1)'($signed(vm_rdata_reg[2*POS_W-1:POS_W]))
                           - (POS_W + 1)'(pa_reg[1]);
                uu_reg[2] <= (POS_W + 1)'($signed(vm_rdata_reg[3*POS_W-1:2*POS_W]))
                           - (POS_W + 1)'(pa_reg[2]);
                for (int i = 0; i < 3; i++) begin
                    vv_reg[i] <= (POS_W + 1)'(pb_reg[i]) - (POS_W + 1)'(pa_reg[i]);
                    n_reg[i]  <= '0;
                end
                cnt_reg <= '0;
            end
            S_XMUL: begin
                // one product per cycle, accumulated in the following cycle
                prod_reg <= mul_a * mul_b;
                if (cnt_reg != 3'd0) begin
                    case (pcnt[2:1])
                        2'd0: n_reg[0] <= pcnt[0] ? n_reg[0] - NIN_W'(prod_reg)
                                                  : n_reg[0] + NIN_W'(prod_reg);
                        2'd1: n_reg[1] <= pcnt[0] ? n_reg[1] - NIN_W'(prod_reg)
                                                  : n_reg[1] + NIN_W'(prod_reg);
                        default: n_reg[2] <= pcnt[0] ? n_reg[2] - NIN_W'(prod_reg)
                                                     : n_reg[2] + NIN_W'(prod_reg);
                    endcase
                end
                cnt_reg <= cnt_reg + 3'd1;
            end
            S_FWAIT: begin
                if (norm_done) begin
                    f_reg[0]     <= norm_res.x;
                    f_reg[1]     <= norm_res.y;
                    f_reg[2]     <= norm_res.z;
                    zero_met_reg <= zero_met_reg | norm_res.zero;
                    sel_reg      <= '0;
                end
            end
            S_AWR: begin
                if (sel_reg == 2'd2) begin
                    tidx_reg <= tidx_reg + TCW'(1);
                end
                sel_reg <= sel_reg + 2'd1;
            end
            S_VCHK: begin
                if (idx_reg == vcount_reg) begin
                    res_st_reg <= zero_met_reg ? ST_ZERO : ST_OK;
                end
            end
            S_VWAIT: begin
                if (norm_done) begin
                    zero_met_reg <= zero_met_reg | norm_res.zero;
                    idx_reg      <= idx_reg + VCW'(1);
                end
            end
            S_RESP: begin
                if (out_free) begin
                    m_tdata_reg <= {res_z_reg, res_y_reg, res_x_reg};
                    m_tuser_reg <= res_st_reg;
                end
            end
            default: begin
            end
        endcase
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef SYNTHESIS
    a_vcount_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        vcount_reg <= VCW'(MAX_VERTICES))
        else $error("vertex count beyond store depth");

    a_tcount_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        tcount_reg <= TCW'(MAX_TRIANGLES))
        else $error("triangle count beyond store depth");

    a_accept_dispatch: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == S_DISP))
        else $error("accepted word not dispatched");

    a_norm_done_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        norm_done |-> (state_reg == S_FWAIT || state_reg == S_VWAIT))
        else $error("normalize result outside a wait state");

    a_store_write_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        (vm_we || tm_we) |-> !am_we)
        else $error("append and accumulate writes overlap");
`endif

endmodule
